// ===== src/lkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the linear key/value table: command codes,
// decoded operations, queued command items and result items.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CMD_BITS         = 3;
    localparam int KEY_FIELD_BITS   = 32;
    localparam int VALUE_FIELD_BITS = 32;
    localparam int COUNT_FIELD_BITS = 5;

    localparam int S_TDATA_BITS     = 64;
    localparam int RESULT_DATA_BITS = 1 + KEY_FIELD_BITS + VALUE_FIELD_BITS
                                      + COUNT_FIELD_BITS + 1;
    localparam int M_TDATA_BITS     = ((RESULT_DATA_BITS + 7) / 8) * 8;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CMD_BITS-1:0] CMD_SET      = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_GET      = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CONTAINS = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_DUMP     = 3'd6;

    typedef enum logic [2:0] {
        OP_SET,
        OP_ADD,
        OP_REMOVE,
        OP_GET,
        OP_CONTAINS,
        OP_CLEAR,
        OP_DUMP,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [KEY_FIELD_BITS-1:0]   key;
        logic [VALUE_FIELD_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic                        found;
        logic [KEY_FIELD_BITS-1:0]   key_out;
        logic [VALUE_FIELD_BITS-1:0] value_out;
        logic [COUNT_FIELD_BITS-1:0] entry_count;
        logic                        full_error;
        logic                        last;
    } result_t;

endpackage
`default_nettype wire

// ===== src/lkv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_front
// Input stage: takes command transfers, decodes the command code into an
// operation and holds the item until the command queue takes it.
// ----------------------------------------------------------------------------
module lkv_front
    import lkv_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [CMD_BITS-1:0]         s_cmd,
    input  wire logic [KEY_FIELD_BITS-1:0]   s_key,
    input  wire logic [VALUE_FIELD_BITS-1:0] s_value,
    output logic                             q_push_valid,
    input  wire logic                        q_push_ready,
    output item_t                            q_push_item
);

    logic  front_valid_reg;
    item_t front_item_reg;
    op_t   op_dec;

    always_comb begin
        unique case (s_cmd)
            CMD_SET:      op_dec = OP_SET;
            CMD_ADD:      op_dec = OP_ADD;
            CMD_REMOVE:   op_dec = OP_REMOVE;
            CMD_GET:      op_dec = OP_GET;
            CMD_CONTAINS: op_dec = OP_CONTAINS;
            CMD_CLEAR:    op_dec = OP_CLEAR;
            CMD_DUMP:     op_dec = OP_DUMP;
            default:      op_dec = OP_NONE;
        endcase
    end

    assign s_ready      = !front_valid_reg || q_push_ready;
    assign q_push_valid = front_valid_reg;
    assign q_push_item  = front_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_item_reg.op    <= op_dec;
            front_item_reg.key   <= s_key;
            front_item_reg.value <= s_value;
        end
    end

endmodule
`default_nettype wire

// ===== src/lkv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_queue
// Short command queue between the input stage and the table engine.
// ----------------------------------------------------------------------------
module lkv_queue
    import lkv_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  item_t     push_item,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output item_t     pop_item
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    item_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = fill_reg != CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_BITS-1:0] ptr_step(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_step(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_step(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/lkv_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_table
// Table engine: a row of key/value cells with a comparator per cell. A
// command is fetched with its key and value matches registered, then
// executed: overwrite, append, remove with shift-down, lookup, clear, or a
// dump that sends one result per entry.
// ----------------------------------------------------------------------------
module lkv_table
    import lkv_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  item_t     pop_item,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_result
);

    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   count_reg;
    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  key_hit_reg;
    logic                  value_hit_reg;
    logic [IDX_BITS-1:0]   pos_reg;
    logic [IDX_BITS-1:0]   dump_idx_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [KEY_BITS-1:0]   key_cell_reg   [DEPTH];
    logic [VALUE_BITS-1:0] value_cell_reg [DEPTH];
    logic [KEY_BITS-1:0]   key_src        [DEPTH];
    logic [VALUE_BITS-1:0] value_src      [DEPTH];

    logic [KEY_BITS-1:0]   head_key;
    logic [VALUE_BITS-1:0] head_value;
    logic                  key_hit;
    logic                  value_hit;
    logic [IDX_BITS-1:0]   pos;

    logic                  out_free;
    logic                  out_load;
    logic                  is_full;
    result_t               exec_res;
    result_t               dump_res;
    logic [CNT_BITS-1:0]   count_next;
    logic                  do_append;
    logic                  do_update;
    logic                  do_shift;
    logic                  go_dump;
    logic                  exec_fire;

    assign head_key   = KEY_BITS'(pop_item.key);
    assign head_value = VALUE_BITS'(pop_item.value);
    assign pop_ready  = state_reg == S_IDLE;
    assign out_free   = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_result   = out_reg;
    assign is_full    = count_reg == CNT_BITS'(DEPTH);
    assign exec_fire  = (state_reg == S_EXEC) && out_free && !go_dump;
    assign out_load   = exec_fire || ((state_reg == S_DUMP) && out_free);

    // per-cell compare against the queue head, only live entries count
    always_comb begin
        key_hit   = 1'b0;
        value_hit = 1'b0;
        pos       = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_BITS'(i) < count_reg) begin
                if (key_cell_reg[i] == head_key) begin
                    key_hit = 1'b1;
                    pos     = pos | IDX_BITS'(i);
                end
                if (value_cell_reg[i] == head_value) begin
                    value_hit = 1'b1;
                end
            end
        end
    end

    always_comb begin
        exec_res      = '0;
        exec_res.last = 1'b1;
        count_next    = count_reg;
        do_append     = 1'b0;
        do_update     = 1'b0;
        do_shift      = 1'b0;
        go_dump       = 1'b0;
        unique case (op_reg)
            OP_SET, OP_ADD: begin
                if (key_hit_reg) begin
                    exec_res.found = 1'b1;
                    do_update      = op_reg == OP_SET;
                end else if (is_full) begin
                    exec_res.full_error = 1'b1;
                end else begin
                    do_append  = 1'b1;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_REMOVE: begin
                if (key_hit_reg) begin
                    exec_res.found = 1'b1;
                    do_shift       = 1'b1;
                    count_next     = count_reg - CNT_BITS'(1);
                end
            end
            OP_GET: begin
                if (key_hit_reg) begin
                    exec_res.found     = 1'b1;
                    exec_res.value_out = VALUE_FIELD_BITS'(value_cell_reg[pos_reg]);
                end
            end
            OP_CONTAINS: begin
                exec_res.found = value_hit_reg;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_DUMP: begin
                go_dump = count_reg != '0;
            end
            OP_NONE: begin
            end
        endcase
        exec_res.entry_count = COUNT_FIELD_BITS'(count_next);
    end

    always_comb begin
        dump_res             = '0;
        dump_res.found       = 1'b1;
        dump_res.key_out     = KEY_FIELD_BITS'(key_cell_reg[dump_idx_reg]);
        dump_res.value_out   = VALUE_FIELD_BITS'(value_cell_reg[dump_idx_reg]);
        dump_res.entry_count = COUNT_FIELD_BITS'(count_reg);
        dump_res.last        = (CNT_BITS'(dump_idx_reg) + CNT_BITS'(1)) == count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop_valid) begin
                        op_reg        <= pop_item.op;
                        key_reg       <= head_key;
                        value_reg     <= head_value;
                        key_hit_reg   <= key_hit;
                        value_hit_reg <= value_hit;
                        pos_reg       <= pos;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go_dump) begin
                        dump_idx_reg <= '0;
                        state_reg    <= S_DUMP;
                    end else if (out_free) begin
                        out_reg       <= exec_res;
                        count_reg     <= count_next;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        out_reg       <= dump_res;
                        if (dump_res.last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            dump_idx_reg <= dump_idx_reg + IDX_BITS'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_tail
            assign key_src[g]   = key_cell_reg[g];
            assign value_src[g] = value_cell_reg[g];
        end else begin : g_body
            assign key_src[g]   = key_cell_reg[g + 1];
            assign value_src[g] = value_cell_reg[g + 1];
        end

        always_ff @(posedge aclk) begin
            if (exec_fire) begin
                if (do_append && (CNT_BITS'(g) == count_reg)) begin
                    key_cell_reg[g]   <= key_reg;
                    value_cell_reg[g] <= value_reg;
                end else if (do_update && (IDX_BITS'(g) == pos_reg)) begin
                    value_cell_reg[g] <= value_reg;
                end else if (do_shift && (IDX_BITS'(g) >= pos_reg)) begin
                    key_cell_reg[g]   <= key_src[g];
                    value_cell_reg[g] <= value_src[g];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above table depth");

    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |-> count_reg != '0)
        else $error("dump running on an empty table");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.full_error
            |-> out_reg.entry_count == COUNT_FIELD_BITS'(DEPTH))
        else $error("full error with table not full");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.found && out_reg.full_error))
        else $error("found and full error together");

endmodule
`default_nettype wire

// ===== src/linear_key_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_key_value_table
// Insertion-ordered key/value table searched by key equality, with set, add,
// remove, get, contains_value, clear and dump commands.
//
//   channel  direction  tdata (low bit up)                   tuser    tlast
//   s_axis   in         key, value                           command  -
//   m_axis   out        found, key_out, value_out,           -        last
//                       entry_count, full_error
//
// each command passes through the table engine as a fetch that compares the
// key and value against every live entry at once, then an execute step that
// waits for the result register to be free; a dump sends one result per entry
// reset clears the entry count, not the stored entries; entries are written before they are read
// the queue and input stage let input transfers continue, until full, while results are stalled
// ----------------------------------------------------------------------------
module linear_key_value_table
    import lkv_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,  // key, value
    input  wire logic [CMD_BITS-1:0]     s_axis_tuser,  // command
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // found, key_out, value_out, entry_count, full_error, zero fill
    output logic [M_TDATA_BITS-1:0]      m_axis_tdata,
    output logic                         m_axis_tlast
);

    logic    q_push_valid;
    logic    q_push_ready;
    item_t   q_push_item;
    logic    q_pop_valid;
    logic    q_pop_ready;
    item_t   q_pop_item;
    result_t result;

    lkv_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_cmd        (s_axis_tuser),
        .s_key        (s_axis_tdata[KEY_FIELD_BITS-1:0]),
        .s_value      (s_axis_tdata[KEY_FIELD_BITS +: VALUE_FIELD_BITS]),
        .q_push_valid (q_push_valid),
        .q_push_ready (q_push_ready),
        .q_push_item  (q_push_item)
    );

    lkv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    lkv_table #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (q_pop_item),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_result  (result)
    );

    assign m_axis_tdata = {
        {(M_TDATA_BITS - RESULT_DATA_BITS){1'b0}},
        result.full_error,
        result.entry_count,
        result.value_out,
        result.key_out,
        result.found
    };
    assign m_axis_tlast = result.last;

endmodule
`default_nettype wire

// ===== tb/sv/linear_key_value_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_key_value_table_test
// Self-checking bench for the linear key/value table. A scoreboard keeps its
// own copy of the table and predicts the results of every accepted command,
// dumps included. Directed commands cover the empty and full table, key and
// value extremes and the unused command code. Random commands on pools of
// keys and values follow, under changing idle rates on both channels and one
// long result stall.
// ----------------------------------------------------------------------------
module linear_key_value_table_test;
    import lkv_pkg::*;

    localparam int TABLE_DEPTH      = DEPTH_DEFAULT;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
    localparam int KEY_POOL_SIZE    = 24;
    localparam int VALUE_POOL_SIZE  = 20;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int STALL_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 64;

    localparam int KEY_LSB   = 1;
    localparam int VALUE_LSB = KEY_LSB + KEY_FIELD_BITS;
    localparam int COUNT_LSB = VALUE_LSB + VALUE_FIELD_BITS;
    localparam int FULL_BIT  = COUNT_LSB + COUNT_FIELD_BITS;

    class table_scoreboard;
        logic [KEY_FIELD_BITS-1:0]   key_store [TABLE_DEPTH];
        logic [VALUE_FIELD_BITS-1:0] value_store [TABLE_DEPTH];
        int                          entries;
        result_t                     pending [$];
        int                          error_count;

        function new();
            entries     = 0;
            error_count = 0;
        endfunction

        function void note_command(input logic [CMD_BITS-1:0] cmd,
                                   input logic [KEY_FIELD_BITS-1:0] key,
                                   input logic [VALUE_FIELD_BITS-1:0] value);
            int      pos;
            result_t r;
            pos = -1;
            for (int i = 0; i < entries; i++) begin
                if (pos < 0 && key_store[i] == key) pos = i;
            end
            r = '0;
            r.last = 1'b1;
            case (cmd)
                CMD_SET, CMD_ADD: begin
                    if (pos >= 0) begin
                        if (cmd == CMD_SET) value_store[pos] = value;
                        r.found = 1'b1;
                    end else if (entries >= TABLE_DEPTH) begin
                        r.full_error = 1'b1;
                    end else begin
                        key_store[entries]   = key;
                        value_store[entries] = value;
                        entries++;
                    end
                end
                CMD_REMOVE: begin
                    if (pos >= 0) begin
                        for (int i = pos; i < entries - 1; i++) begin
                            key_store[i]   = key_store[i + 1];
                            value_store[i] = value_store[i + 1];
                        end
                        entries--;
                        r.found = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (pos >= 0) begin
                        r.found     = 1'b1;
                        r.value_out = value_store[pos];
                    end
                end
                CMD_CONTAINS: begin
                    for (int i = 0; i < entries; i++) begin
                        if (value_store[i] == value) r.found = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    entries = 0;
                end
                CMD_DUMP: begin
                    if (entries > 0) begin
                        for (int i = 0; i < entries; i++) begin
                            r.found       = 1'b1;
                            r.key_out     = key_store[i];
                            r.value_out   = value_store[i];
                            r.entry_count = COUNT_FIELD_BITS'(entries);
                            r.last        = (i == entries - 1);
                            pending.push_back(r);
                        end
                        return;
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = COUNT_FIELD_BITS'(entries);
            pending.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] expected,
                                    input logic [31:0] actual);
            if (expected !== actual) begin
                $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
                error_count++;
            end
        endfunction

        function void check_result(input logic [M_TDATA_BITS-1:0] data,
                                   input logic last_flag);
            result_t exp_r;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", data);
                error_count++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("found", 32'(exp_r.found), 32'(data[0]));
            compare_field("key_out", exp_r.key_out, data[KEY_LSB +: KEY_FIELD_BITS]);
            compare_field("value_out", exp_r.value_out,
                          data[VALUE_LSB +: VALUE_FIELD_BITS]);
            compare_field("entry_count", 32'(exp_r.entry_count),
                          32'(data[COUNT_LSB +: COUNT_FIELD_BITS]));
            compare_field("full_error", 32'(exp_r.full_error), 32'(data[FULL_BIT]));
            compare_field("last", 32'(exp_r.last), 32'(last_flag));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;  // key, value
    logic [CMD_BITS-1:0]     s_axis_tuser;  // command
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // found, key_out, value_out, entry_count, full_error, zero fill
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    table_scoreboard sb = new();

    int                          send_idle_pct;
    int                          recv_idle_pct;
    bit                          hold_request;
    int                          stall_cycles;
    logic [KEY_FIELD_BITS-1:0]   key_pool [KEY_POOL_SIZE];
    logic [VALUE_FIELD_BITS-1:0] value_pool [VALUE_POOL_SIZE];

    linear_key_value_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                                input logic [KEY_FIELD_BITS-1:0] key,
                                input logic [VALUE_FIELD_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            // noise on the data lines while invalid
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom(), $urandom()};
            s_axis_tuser  <= CMD_BITS'($urandom());
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_command(cmd, key, value);
    endtask

    task automatic send_random_command();
        logic [CMD_BITS-1:0]         cmd;
        logic [KEY_FIELD_BITS-1:0]   key;
        logic [VALUE_FIELD_BITS-1:0] value;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < 30)      cmd = CMD_SET;
        else if (pick < 48) cmd = CMD_ADD;
        else if (pick < 63) cmd = CMD_REMOVE;
        else if (pick < 78) cmd = CMD_GET;
        else if (pick < 88) cmd = CMD_CONTAINS;
        else if (pick < 91) cmd = CMD_CLEAR;
        else if (pick < 97) cmd = CMD_DUMP;
        else                cmd = CMD_UNUSED;
        key   = ($urandom_range(9) == 0) ? $urandom()
                                         : key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        value = ($urandom_range(3) == 0) ? $urandom()
                                         : value_pool[$urandom_range(VALUE_POOL_SIZE - 1)];
        send_command(cmd, key, value);
    endtask

    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        stall_cycles  = 0;
        key_pool[0]   = '0;
        key_pool[1]   = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < VALUE_POOL_SIZE; i++) value_pool[i] = $urandom();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 58;

        // empty table
        send_command(CMD_DUMP, 32'h0, 32'h0);
        send_command(CMD_GET, 32'h7, 32'h0);
        send_command(CMD_REMOVE, 32'h7, 32'h0);
        send_command(CMD_CONTAINS, 32'h0, 32'h0);
        // extremes, overwrite and add of a present key
        send_command(CMD_SET, 32'h0, 32'h0);
        send_command(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_ADD, 32'h0, 32'h1);
        send_command(CMD_SET, 32'h0, 32'hAAAA_5555);
        send_command(CMD_GET, 32'h0, 32'h0);
        send_command(CMD_CONTAINS, 32'h0, 32'hFFFF_FFFF);
        send_command(CMD_UNUSED, $urandom(), $urandom());
        // fill up, then refused appends
        for (int k = 1; k <= TABLE_DEPTH - 2; k++) send_command(CMD_ADD, k, $urandom());
        send_command(CMD_ADD, 32'h100, 32'h1);
        send_command(CMD_SET, 32'h101, 32'h2);
        send_command(CMD_REMOVE, 32'h0, 32'h0);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_DUMP, 32'h0, 32'h0);
        send_command(CMD_CLEAR, 32'h0, 32'h0);
        send_command(CMD_DUMP, 32'h0, 32'h0);

        repeat (RANDOM_PER_PHASE) send_random_command();
        send_idle_pct = 58;
        recv_idle_pct = 25;
        repeat (RANDOM_PER_PHASE) send_random_command();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long result stall while commands keep coming
        hold_request  = 1;
        repeat (RANDOM_PER_PHASE) send_random_command();

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
